@@ rtl/core/dltq_pkg.sv @@
// Shared types and constants of the delta list timer queue.
// Used by dltq_alu, dltq_scale and delta_list_timer_queue.
`default_nettype none

package dltq_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int MAX_RESULTS = 16;

	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam int LEN_W = $clog2(NUM_TIMERS + 1);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam int CMD_W    = 2;
	localparam int ID_W     = 4;
	localparam int DELAY_W  = 32;
	localparam int DELTA_W  = 32;
	localparam int RATE_W   = 16;
	localparam int STATUS_W = 2;
	localparam int PROD_W   = RATE_W + DELAY_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int MS_PER_SECOND = 1000;
	localparam int REM_W         = $clog2(MS_PER_SECOND);

	localparam logic [RATE_W-1:0]  RATE_RESET   = RATE_W'(32 * 1024);
	localparam logic [DELAY_W-1:0] MAX_DELAY_MS = DELAY_W'((64'hFFFF_FFFF >> 15) * 64'd1000);

	localparam logic [PADDR_W-3:0] REG_TICK_RATE = '0;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_QUEUED     = 2'd1,
		ST_TOO_LONG   = 2'd2,
		ST_NOT_QUEUED = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ACK    = 1'b0,
		KIND_EXPIRY = 1'b1
	} kind_t;

	typedef enum logic {
		ALU_SUB_SAT = 1'b0,
		ALU_ADD_SAT = 1'b1
	} alu_op_t;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		alu_op_t            op;
		logic [DELTA_W-1:0] a;
		logic [DELTA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [DELTA_W-1:0] y;
		logic               carry;
	} alu_rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [DELTA_W-1:0] delta;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/core/dltq_alu.sv @@
// Shared delta unit: one adder doing saturating subtract or saturating add.
// Depends on dltq_pkg.
`default_nettype none

module dltq_alu import dltq_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic             sub;
	logic [DELTA_W:0] sum;

	assign sub = (req.op == ALU_SUB_SAT);
	assign sum = {1'b0, req.a} + {1'b0, (sub ? ~req.b : req.b)} + (DELTA_W + 1)'(sub);

	always_comb begin
		rsp.carry = sum[DELTA_W];
		unique case (req.op)
			ALU_SUB_SAT: rsp.y = sum[DELTA_W] ? sum[DELTA_W-1:0] : '0;
			ALU_ADD_SAT: rsp.y = sum[DELTA_W] ? '1 : sum[DELTA_W-1:0];
			default:     rsp.y = sum[DELTA_W-1:0];
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/dltq_scale.sv @@
// Millisecond to tick conversion: one multiply, then a divide by 1000 taken one
// 16-bit chunk at a time by reciprocal multiplication. Depends on dltq_pkg.
`default_nettype none

module dltq_scale import dltq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RATE_W-1:0]  rate,
	input  logic [DELAY_W-1:0] ms,
	output logic               done,
	output logic [DELTA_W-1:0] ticks
);

	localparam int CHUNK_W    = 16;
	localparam int NUM_CHUNKS = PROD_W / CHUNK_W;
	localparam int NUM_STEPS  = 2 * NUM_CHUNKS;
	localparam int STEP_W     = $clog2(NUM_STEPS);
	localparam int X_W        = REM_W + CHUNK_W;
	localparam int RECIP_SH   = X_W + REM_W;
	localparam int RECIP_W    = X_W + 1;
	localparam int RECIP_P_W  = X_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SH)
		+ 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));
	localparam logic [X_W-1:0] DIVISOR = X_W'(MS_PER_SECOND);

	logic [PROD_W-1:0]    quo_q;
	logic [REM_W-1:0]     rem_q;
	logic [CHUNK_W-1:0]   dig_q;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [X_W-1:0]       x;
	logic [RECIP_P_W-1:0] recip_p;
	logic [X_W-1:0]       back;

	assign x       = {rem_q, quo_q[PROD_W-1 -: CHUNK_W]};
	assign recip_p = {{RECIP_W{1'b0}}, x} * {{X_W{1'b0}}, RECIP};
	assign back    = X_W'(dig_q) * DIVISOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(NUM_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {{DELAY_W{1'b0}}, rate} * {{RATE_W{1'b0}}, ms};
			rem_q <= '0;
		end else if (busy_q) begin
			if (!step_q[0]) begin
				dig_q <= recip_p[RECIP_SH +: CHUNK_W];
			end else begin
				rem_q <= REM_W'(x - back);
				quo_q <= {quo_q[PROD_W-CHUNK_W-1:0], dig_q};
			end
		end
	end

	// saturate a quotient that does not fit a delta
	assign ticks = (|quo_q[PROD_W-1:DELTA_W]) ? '1 : quo_q[DELTA_W-1:0];
	assign done  = done_q;

endmodule

`default_nettype wire

@@ rtl/core/delta_list_timer_queue.sv @@
// Rejected adds and deletes go straight to their ack. An add converts the delay to ticks,
// walks the list and shifts later entries up; a delete finds its entry and shifts later
// ones down. A tick decrements the head delta, pops each expired timer and gives no ack.
// One word in flight; ready again once its last result, if any, enters the output register.
// Throughput is set by the single list memory port pair and the shared delta adder.
// Reset clears list length, queued mask and output valid, tick_rate to 32768; no memory clear.
`default_nettype none

module delta_list_timer_queue import dltq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [ID_W-1:0]     timer_id,
	input  logic [DELAY_W-1:0]  delay_ms,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                result_kind,
	output logic [ID_W-1:0]     fired_id,
	output logic [STATUS_W-1:0] status,
	output logic                last,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	typedef enum logic [13:0] {
		S_IDLE     = 14'h0001,
		S_SCALE    = 14'h0002,
		S_WALK_RD  = 14'h0004,
		S_WALK_CMP = 14'h0008,
		S_SH_RD    = 14'h0010,
		S_SH_WR    = 14'h0020,
		S_PUT      = 14'h0040,
		S_FIND_RD  = 14'h0080,
		S_FIND_CMP = 14'h0100,
		S_UNLINK   = 14'h0200,
		S_TICK_RD  = 14'h0400,
		S_TICK_CMP = 14'h0800,
		S_POP      = 14'h1000,
		S_EMIT     = 14'h2000
	} state_t;

	state_t                state_q;
	len_t                  len_q;
	logic [NUM_TIMERS-1:0] mask_q;
	logic [RATE_W-1:0]     rate_q;
	logic                  res_valid_q;

	cmd_t               cmd_q;
	logic [ID_W-1:0]    id_q;
	idx_t               idx_q;
	idx_t               ptr_q;
	idx_t               pos_q;
	idx_t               src_q;
	logic               up_q;
	logic               fix_q;
	logic [DELTA_W-1:0] t_q;
	cnt_t               n_q;
	logic [ID_W-1:0]    pend_id_q;

	kind_t           stg_kind_q;
	logic [ID_W-1:0] stg_id_q;
	status_t         stg_status_q;
	logic            stg_last_q;

	kind_t           res_kind_q;
	logic [ID_W-1:0] res_id_q;
	status_t         res_status_q;
	logic            res_last_q;

	entry_t mem_q [NUM_TIMERS];
	entry_t rdata_q;
	idx_t   rd_addr;
	logic   we;
	idx_t   waddr;
	entry_t wdata;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic               sc_start;
	logic               sc_done;
	logic [DELTA_W-1:0] sc_ticks;

	logic    accept_cmd;
	logic    emit_fire;
	logic    cfg_wr;
	idx_t    in_idx;
	logic    id_bad;
	logic    id_queued;
	logic    delay_bad;
	logic    list_full;
	status_t ack_status;
	idx_t    len_m1_idx;
	logic    ptr_last;
	logic    src_at_pos;
	logic    src_last;
	logic    cur_fix;
	logic    id_match;
	logic    exp_more;

	assign cmd_ready  = (state_q == S_IDLE);
	assign accept_cmd = cmd_valid && cmd_ready;
	assign emit_fire  = (state_q == S_EMIT) && (!res_valid_q || res_ready);
	assign cfg_wr     = psel && penable && pwrite && pready;

	assign in_idx    = idx_t'(timer_id);
	assign id_bad    = (32'(timer_id) >= NUM_TIMERS);
	assign id_queued = mask_q[in_idx];
	assign delay_bad = (delay_ms > MAX_DELAY_MS);
	assign list_full = (len_q >= LEN_W'(NUM_TIMERS));
	assign sc_start  = accept_cmd && (cmd_t'(command) == CMD_ADD) && !id_bad && !id_queued
		&& !delay_bad && !list_full;

	always_comb begin
		ack_status = ST_NOT_QUEUED;
		if (cmd_t'(command) == CMD_ADD) begin
			if (id_bad)
				ack_status = ST_NOT_QUEUED;
			else if (id_queued)
				ack_status = ST_QUEUED;
			else if (delay_bad)
				ack_status = ST_TOO_LONG;
			else if (list_full)
				ack_status = ST_QUEUED;
			else
				ack_status = ST_OK;
		end else if (!id_bad && id_queued) begin
			ack_status = ST_OK;
		end
	end

	assign len_m1_idx = idx_t'(len_q - LEN_W'(1));
	assign ptr_last   = ((LEN_W'(ptr_q) + LEN_W'(1)) == len_q);
	assign src_at_pos = (src_q == pos_q);
	assign src_last   = (src_q == len_m1_idx);
	assign cur_fix    = fix_q && (up_q ? src_at_pos : (src_q == pos_q + idx_t'(1)));
	assign id_match   = (rdata_q.id == id_q);
	assign exp_more   = (len_q != LEN_W'(1)) && ((n_q + CNT_W'(1)) < CNT_W'(MAX_RESULTS));

	dltq_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.rate   (rate_q),
		.ms     (delay_ms),
		.done   (sc_done),
		.ticks  (sc_ticks)
	);

	always_comb begin
		alu_req.op = ALU_SUB_SAT;
		alu_req.a  = t_q;
		alu_req.b  = rdata_q.delta;
		if (state_q == S_SH_WR) begin
			alu_req.op = up_q ? ALU_SUB_SAT : ALU_ADD_SAT;
			alu_req.a  = rdata_q.delta;
			alu_req.b  = t_q;
		end else if (state_q == S_TICK_CMP) begin
			alu_req.a = rdata_q.delta;
			alu_req.b = DELTA_W'(1);
		end
	end

	dltq_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_comb begin
		rd_addr = ptr_q;
		if (state_q == S_SH_RD)
			rd_addr = src_q;
		else if (state_q == S_TICK_RD)
			rd_addr = '0;
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = '{id: id_q, delta: t_q};
		if (state_q == S_SH_WR) begin
			we    = 1'b1;
			waddr = up_q ? (src_q + idx_t'(1)) : (src_q - idx_t'(1));
			wdata = '{id: rdata_q.id, delta: (cur_fix ? alu_rsp.y : rdata_q.delta)};
		end else if (state_q == S_PUT) begin
			we = 1'b1;
		end else if (state_q == S_TICK_CMP) begin
			we    = (n_q == '0) && (alu_rsp.y != '0);
			waddr = '0;
			wdata = '{id: rdata_q.id, delta: alu_rsp.y};
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			mask_q      <= '0;
			rate_q      <= RATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[PADDR_W-1:2] == REG_TICK_RATE))
				rate_q <= pwdata[RATE_W-1:0];

			if (emit_fire)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept_cmd) begin
						unique case (cmd_t'(command))
							CMD_ADD:    state_q <= sc_start ? S_SCALE : S_EMIT;
							CMD_DELETE: state_q <= (id_bad || !id_queued) ? S_EMIT : S_FIND_RD;
							CMD_TICK:   state_q <= (len_q != '0) ? S_TICK_RD : S_IDLE;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_SCALE: begin
					if (sc_done)
						state_q <= (len_q == '0) ? S_PUT : S_WALK_RD;
				end
				S_WALK_RD: state_q <= S_WALK_CMP;
				S_WALK_CMP: begin
					if (alu_rsp.carry)
						state_q <= ptr_last ? S_PUT : S_WALK_RD;
					else
						state_q <= S_SH_RD;
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					if (up_q && src_at_pos)
						state_q <= S_PUT;
					else if (!up_q && src_last)
						state_q <= S_UNLINK;
					else
						state_q <= S_SH_RD;
				end
				S_PUT: begin
					len_q         <= len_q + LEN_W'(1);
					mask_q[idx_q] <= 1'b1;
					state_q       <= S_EMIT;
				end
				S_FIND_RD: state_q <= S_FIND_CMP;
				S_FIND_CMP: begin
					if (id_match) begin
						state_q <= ptr_last ? S_UNLINK : S_SH_RD;
					end else if (ptr_last) begin
						mask_q[idx_q] <= 1'b0;
						state_q       <= S_EMIT;
					end else begin
						state_q <= S_FIND_RD;
					end
				end
				S_UNLINK: begin
					len_q         <= len_q - LEN_W'(1);
					mask_q[idx_q] <= 1'b0;
					if (cmd_q == CMD_TICK && exp_more)
						state_q <= S_TICK_RD;
					else
						state_q <= S_EMIT;
				end
				S_TICK_RD: state_q <= S_TICK_CMP;
				S_TICK_CMP: begin
					if (n_q == '0)
						state_q <= (alu_rsp.y != '0) ? S_IDLE : S_POP;
					else
						state_q <= S_EMIT;
				end
				S_POP: state_q <= (len_q > LEN_W'(1)) ? S_SH_RD : S_UNLINK;
				S_EMIT: begin
					if (emit_fire)
						state_q <= stg_last_q ? S_IDLE : S_POP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			res_kind_q   <= stg_kind_q;
			res_id_q     <= stg_id_q;
			res_status_q <= stg_status_q;
			res_last_q   <= stg_last_q;
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept_cmd) begin
					cmd_q        <= cmd_t'(command);
					id_q         <= timer_id;
					idx_q        <= in_idx;
					ptr_q        <= '0;
					pos_q        <= '0;
					n_q          <= '0;
					stg_kind_q   <= KIND_ACK;
					stg_id_q     <= timer_id;
					stg_status_q <= ack_status;
					stg_last_q   <= 1'b1;
				end
			end
			S_SCALE: begin
				if (sc_done)
					t_q <= sc_ticks;
			end
			S_WALK_CMP: begin
				if (alu_rsp.carry) begin
					t_q   <= alu_rsp.y;
					ptr_q <= ptr_q + idx_t'(1);
					pos_q <= ptr_q + idx_t'(1);
				end else begin
					pos_q <= ptr_q;
					src_q <= len_m1_idx;
					up_q  <= 1'b1;
					fix_q <= 1'b1;
				end
			end
			S_SH_WR: src_q <= up_q ? (src_q - idx_t'(1)) : (src_q + idx_t'(1));
			S_FIND_CMP: begin
				ptr_q <= ptr_q + idx_t'(1);
				if (id_match) begin
					pos_q <= ptr_q;
					src_q <= ptr_q + idx_t'(1);
					t_q   <= rdata_q.delta;
					up_q  <= 1'b0;
					fix_q <= 1'b1;
				end else if (ptr_last) begin
					stg_status_q <= ST_NOT_QUEUED;
				end
			end
			S_UNLINK: begin
				n_q <= n_q + CNT_W'(1);
				if (cmd_q == CMD_TICK) begin
					stg_kind_q   <= KIND_EXPIRY;
					stg_id_q     <= pend_id_q;
					stg_status_q <= ST_OK;
					stg_last_q   <= 1'b1;
				end
			end
			S_TICK_CMP: begin
				if (n_q == '0) begin
					pend_id_q <= rdata_q.id;
				end else begin
					stg_kind_q   <= KIND_EXPIRY;
					stg_id_q     <= pend_id_q;
					stg_status_q <= ST_OK;
					stg_last_q   <= (rdata_q.delta != '0);
					pend_id_q    <= rdata_q.id;
				end
			end
			S_POP: begin
				idx_q <= idx_t'(pend_id_q);
				pos_q <= '0;
				src_q <= idx_t'(1);
				up_q  <= 1'b0;
				fix_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign res_valid   = res_valid_q;
	assign result_kind = res_kind_q;
	assign fired_id    = res_id_q;
	assign status      = res_status_q;
	assign last        = res_last_q;

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_TICK_RATE) ? PDATA_W'(rate_q) : '0;

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(NUM_TIMERS))
		else $error("queue length beyond timer count");

	a_mask_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(mask_q) == 32'(len_q)))
		else $error("queued mask disagrees with queue length");

	a_scale_done: assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> (state_q == S_SCALE))
		else $error("tick conversion finished outside add");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (LEN_W'(waddr) <= len_q))
		else $error("list write past queue end");
`endif

endmodule

`default_nettype wire
